// ===== rtl/timed_actuator_preset_control_macros.svh =====
`ifndef TIMED_ACTUATOR_PRESET_CONTROL_MACROS_SVH
`define TIMED_ACTUATOR_PRESET_CONTROL_MACROS_SVH

// Check that cons holds in the same cycle as ante; off while rst is high.
`define TACP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante; off while rst is high.
`define TACP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tacp_pkg.sv =====
`timescale 1ns / 1ps

package tacp_pkg;

  // Field and state widths
  localparam int POS_W      = 16;
  localparam int TIME_W     = 32;
  localparam int GAP_W      = 8;
  localparam int TOL_W      = 8;
  localparam int OVR_W      = 10;
  localparam int EVT_W      = 3;
  localparam int SEL_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 24;

  localparam logic [POS_W-1:0] POS_MAX      = '1;
  localparam logic [POS_W-1:0] FEET_DEFAULT = POS_W'(9999);
  localparam logic [POS_W-1:0] FLAT_DEFAULT = POS_W'(10000);

  // Register reset values
  localparam logic             MEASURING_RST = 1'b0;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = TOL_W'(20);
  localparam logic [OVR_W-1:0] OVERRUN_RST   = OVR_W'(250);
  localparam logic [GAP_W-1:0] GAP_RST       = GAP_W'(50);

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESSED = 3'd1,
    EV_SINGLE  = 3'd2,
    EV_DOUBLE  = 3'd3,
    EV_LONG    = 3'd4
  } event_t;

  typedef enum logic [SEL_W-1:0] {
    GOTO_NONE    = 2'd0,
    GOTO_UPRIGHT = 2'd1,
    GOTO_FEET    = 2'd2,
    GOTO_FLAT    = 2'd3
  } goto_t;

  typedef enum logic [SEL_W-1:0] {
    PRE_NONE      = 2'd0,
    PRE_SAVE_FEET = 2'd1,
    PRE_SAVE_FLAT = 2'd2,
    PRE_LOAD      = 2'd3
  } preset_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEASURING = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_OVERRUN   = 2'd2,
    CFG_GAP       = 2'd3
  } cfg_idx_t;

  // Motion state of the actuator
  typedef struct packed {
    dir_t              dir;
    logic [POS_W-1:0]  base;
    logic [TIME_W-1:0] move_start;
    logic [TIME_W-1:0] stop_time;
    logic              armed;
    logic [GAP_W-1:0]  gap;
  } motion_t;

  // Settings the target unit needs
  typedef struct packed {
    logic [TOL_W-1:0] tol;
    logic [OVR_W-1:0] overrun;
    logic [GAP_W-1:0] rgap;
  } goto_cfg_t;

  // Input item layout, lowest field last
  typedef struct packed {
    logic [5:0]       pad;
    logic [POS_W-1:0] flat_value;
    logic [POS_W-1:0] feet_value;
    logic [SEL_W-1:0] preset_request;
    logic [SEL_W-1:0] goto_request;
    logic [EVT_W-1:0] down_event;
    logic [EVT_W-1:0] up_event;
  } in_item_t;

  // Result item layout, lowest field last
  typedef struct packed {
    logic [2:0]       pad;
    logic             did_work;
    dir_t             direction;
    logic [POS_W-1:0] position;
    logic             down_relay;
    logic             up_relay;
  } out_item_t;

  // Zero stays zero; above flat pins to flat unless measuring
  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] raw,
                                                 input logic [POS_W-1:0] flat,
                                                 input logic measuring);
    logic [POS_W-1:0] r;
    r = raw;
    if (raw != '0 && raw > flat && !measuring) r = flat;
    return r;
  endfunction

endpackage

// ===== rtl/tacp_goto.sv =====
`timescale 1ns / 1ps

module tacp_goto (
  input  tacp_pkg::motion_t             m_in,
  input  logic [tacp_pkg::POS_W-1:0]    cur,
  input  logic [tacp_pkg::POS_W-1:0]    target,
  input  logic [tacp_pkg::POS_W-1:0]    flat,
  input  logic [tacp_pkg::TIME_W-1:0]   tick,
  input  tacp_pkg::goto_cfg_t           cfg,
  input  logic                          enable,
  output tacp_pkg::motion_t             m_out,
  output logic                          restarted
);
  import tacp_pkg::*;

  logic [POS_W:0]    cur_x;
  logic [POS_W:0]    tgt_x;
  logic [POS_W:0]    tol_x;
  logic              above;
  logic              below;
  logic              at_end;
  logic [POS_W-1:0]  travel;
  logic [POS_W:0]    dist_full;
  logic [TIME_W-1:0] from;
  motion_t           m_dir;

  // Compare target with the tolerance window around the position
  always_comb begin
    cur_x     = {1'b0, cur};
    tgt_x     = {1'b0, target};
    tol_x     = (POS_W+1)'(cfg.tol);
    above     = tgt_x > cur_x + tol_x;
    below     = tgt_x + tol_x < cur_x;
    at_end    = (target == '0) || (target == flat);
    travel    = above ? target - cur : cur - target;
    dist_full = {1'b0, travel} + (at_end ? (POS_W+1)'(cfg.overrun) : '0);
  end

  // Start, reverse or keep the motion toward the target
  always_comb begin
    m_dir     = m_in;
    restarted = 1'b0;
    if (above) begin
      if (m_in.dir == DIR_UP) begin
        m_dir.base       = cur;
        m_dir.dir        = DIR_DOWN;
        m_dir.gap        = cfg.rgap;
        m_dir.move_start = tick + TIME_W'(cfg.rgap);
        restarted        = enable;
      end else if (m_in.dir == DIR_STOP) begin
        m_dir.dir        = DIR_DOWN;
        m_dir.gap        = '0;
        m_dir.move_start = tick;
        restarted        = enable;
      end
    end else begin
      if (m_in.dir == DIR_DOWN) begin
        m_dir.base       = cur;
        m_dir.dir        = DIR_UP;
        m_dir.gap        = cfg.rgap;
        m_dir.move_start = tick + TIME_W'(cfg.rgap);
        restarted        = enable;
      end else if (m_in.dir == DIR_STOP) begin
        m_dir.dir        = DIR_UP;
        m_dir.gap        = '0;
        m_dir.move_start = tick;
        restarted        = enable;
      end
    end
    if (!(above || below)) restarted = 1'b0;
  end

  // Arm the off time, counted from the end of any dead time
  always_comb begin
    from  = (m_dir.gap != '0) ? m_dir.move_start : tick;
    m_out = m_in;
    if (enable && (above || below)) begin
      m_out           = m_dir;
      m_out.stop_time = from + TIME_W'(dist_full);
      m_out.armed     = 1'b1;
    end
  end

endmodule

// ===== rtl/timed_actuator_preset_control.sv =====
`timescale 1ns / 1ps
`include "timed_actuator_preset_control_macros.svh"
// Timed actuator with presets: one input transaction is one millisecond tick.
// s_axis carries the button events, goto and preset requests and load values;
// m_axis returns one result per tick: relay drives, estimated position,
// direction and a flag that a button event was handled.
// cfg_wen/cfg_index/cfg_wdata write the four settings; write only while idle.
// A transaction passes through the input register and then the result register
// before it shows on m_axis. Throughput: one tick per cycle while m_axis is not
// stalled, set by the single pass of the tick logic between the two registers.
// The input register takes a new tick while a result waits on m_axis; when the
// receiver stalls, the result register holds and the input register fills,
// then s_axis_tready drops until the result is taken.
// Reset (rst, synchronous) stops motion, clears the tick counter and off time,
// restores presets 9999/10000 and the default settings, and empties both
// registers.

module timed_actuator_preset_control (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // up_event[2:0], down_event[5:3], goto_request[7:6], preset_request[9:8],
  // feet_value[25:10], flat_value[41:26], zero[47:42]
  input  logic [tacp_pkg::IN_W-1:0]        s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // up_relay[0], down_relay[1], position[17:2], direction[19:18],
  // did_work[20], zero[23:21]
  output logic [tacp_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                             cfg_wen,
  input  logic [tacp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tacp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tacp_pkg::*;

  // Settings
  logic             measuring_mode;
  logic [TOL_W-1:0] target_tolerance;
  logic [OVR_W-1:0] end_overrun;
  logic [GAP_W-1:0] reversal_gap;
  goto_cfg_t        gcfg;

  // Stages
  logic      in_v;
  in_item_t  in_q;
  logic      out_v;
  out_item_t out_q;
  out_item_t out_next;
  logic      fire;

  // Tick state
  logic [TIME_W-1:0] tick;
  logic [TIME_W-1:0] tick_next;
  motion_t           motion;
  motion_t           motion_next;
  logic [POS_W-1:0]  feet_preset;
  logic [POS_W-1:0]  feet_preset_next;
  logic [POS_W-1:0]  flat_preset;
  logic [POS_W-1:0]  flat_preset_next;

  // Tick logic
  logic [TIME_W-1:0] elapsed_full;
  logic [TIME_W-1:0] stop_diff;
  logic [POS_W-1:0]  elapsed;
  logic [POS_W:0]    down_sum;
  logic [POS_W-1:0]  raw0;
  logic [POS_W-1:0]  est0;
  logic              expired;
  logic              any_ev;
  logic              in_span;
  logic              do_stop;
  logic [POS_W:0]    feet_lo;
  logic [POS_W:0]    feet_hi;
  motion_t           m1;
  motion_t           m2a;
  motion_t           m2;
  motion_t           m4;
  logic              fresh1;
  logic              fresh2a;
  logic              fresh2;
  logic              fresh4;
  logic              goto2_en;
  logic [POS_W-1:0]  goto2_tgt;
  logic              restart2;
  logic [POS_W-1:0]  raw3;
  logic [POS_W-1:0]  cur3;
  logic              goto4_en;
  logic [POS_W-1:0]  goto4_tgt;
  logic              restart4;
  logic [POS_W-1:0]  raw5;

  assign gcfg.tol     = target_tolerance;
  assign gcfg.overrun = end_overrun;
  assign gcfg.rgap    = reversal_gap;

  // Handshake: process when the result register is free or draining
  assign fire          = in_v && (!out_v || m_axis_tready);
  assign s_axis_tready = !in_v || fire;
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_q;

  // Write settings
  always_ff @(posedge clk) begin
    if (rst) begin
      measuring_mode   <= MEASURING_RST;
      target_tolerance <= TOLERANCE_RST;
      end_overrun      <= OVERRUN_RST;
      reversal_gap     <= GAP_RST;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MEASURING: measuring_mode   <= cfg_wdata[0];
        CFG_TOLERANCE: target_tolerance <= cfg_wdata[TOL_W-1:0];
        CFG_OVERRUN:   end_overrun      <= cfg_wdata[OVR_W-1:0];
        CFG_GAP:       reversal_gap     <= cfg_wdata[GAP_W-1:0];
      endcase
    end
  end

  // Dead-reckoning estimate from the stored state; off-time check
  always_comb begin
    elapsed_full = tick - motion.move_start;
    if (motion.gap != '0) begin
      elapsed = '0;
    end else if (elapsed_full > TIME_W'(POS_MAX)) begin
      elapsed = POS_MAX;
    end else begin
      elapsed = elapsed_full[POS_W-1:0];
    end
    down_sum = {1'b0, motion.base} + {1'b0, elapsed};
    if (motion.dir == DIR_UP) begin
      raw0 = (elapsed >= motion.base) ? '0 : motion.base - elapsed;
    end else if (motion.dir == DIR_DOWN) begin
      raw0 = down_sum[POS_W] ? POS_MAX : down_sum[POS_W-1:0];
    end else begin
      raw0 = motion.base;
    end
    est0      = clamp_pos(raw0, flat_preset, measuring_mode);
    stop_diff = tick - motion.stop_time;
    expired   = motion.armed && !stop_diff[TIME_W-1];
  end

  // Stop at the off time, then handle the buttons
  always_comb begin
    m1     = motion;
    fresh1 = 1'b0;
    if (expired) begin
      m1.base  = est0;
      m1.dir   = DIR_STOP;
      m1.armed = 1'b0;
      m1.gap   = '0;
      fresh1   = 1'b1;
    end

    any_ev    = (in_q.up_event != EV_NONE) || (in_q.down_event != EV_NONE);
    in_span   = (est0 != '0) && (est0 < flat_preset);
    feet_lo   = {1'b0, est0} + (POS_W+1)'(target_tolerance);
    feet_hi   = {1'b0, feet_preset} + (POS_W+1)'(target_tolerance);
    m2a       = m1;
    fresh2a   = fresh1;
    goto2_en  = 1'b0;
    goto2_tgt = '0;
    do_stop   = 1'b0;

    if (any_ev) begin
      if (m1.dir == DIR_STOP) begin
        if (in_q.down_event == EV_PRESSED) begin
          m2a.dir        = DIR_DOWN;
          m2a.gap        = '0;
          m2a.move_start = tick;
          fresh2a        = 1'b1;
        end else if (in_q.up_event == EV_PRESSED) begin
          m2a.dir        = DIR_UP;
          m2a.gap        = '0;
          m2a.move_start = tick;
          fresh2a        = 1'b1;
        end
      end else if (!in_span) begin
        do_stop = 1'b1;
      end else if (in_q.down_event == EV_PRESSED || in_q.up_event == EV_PRESSED) begin
        do_stop = 1'b1;
      end else if (in_q.down_event == EV_SINGLE || in_q.up_event == EV_SINGLE) begin
        goto2_en = 1'b1;
        if (m1.dir == DIR_UP) begin
          goto2_tgt = (feet_lo < {1'b0, feet_preset}) ? '0 : feet_preset;
        end else begin
          goto2_tgt = ({1'b0, est0} < feet_hi) ? feet_preset : flat_preset;
        end
      end else if (in_q.down_event == EV_DOUBLE || in_q.up_event == EV_DOUBLE) begin
        goto2_en  = 1'b1;
        goto2_tgt = (m1.dir == DIR_UP) ? '0 : flat_preset;
      end else if (in_q.down_event == EV_LONG || in_q.up_event == EV_LONG) begin
        do_stop = 1'b1;
      end
    end

    if (do_stop) begin
      m2a.base  = est0;
      m2a.dir   = DIR_STOP;
      m2a.armed = 1'b0;
      m2a.gap   = '0;
      fresh2a   = 1'b1;
    end
  end

  tacp_goto u_goto_button (
    .m_in      (m2a),
    .cur       (est0),
    .target    (goto2_tgt),
    .flat      (flat_preset),
    .tick      (tick),
    .cfg       (gcfg),
    .enable    (goto2_en),
    .m_out     (m2),
    .restarted (restart2)
  );

  // Save or load presets, then pick the requested target
  always_comb begin
    fresh2           = fresh2a || restart2;
    feet_preset_next = feet_preset;
    flat_preset_next = flat_preset;
    case (preset_t'(in_q.preset_request))
      PRE_SAVE_FEET: feet_preset_next = m2.base;
      PRE_SAVE_FLAT: flat_preset_next = m2.base;
      PRE_LOAD: begin
        if (in_q.feet_value != '0 && in_q.flat_value != '0) begin
          feet_preset_next = in_q.feet_value;
          flat_preset_next = in_q.flat_value;
        end else begin
          feet_preset_next = FEET_DEFAULT;
          flat_preset_next = FLAT_DEFAULT;
        end
      end
      default: ;
    endcase

    raw3     = fresh2 ? m2.base : raw0;
    cur3     = clamp_pos(raw3, flat_preset_next, measuring_mode);
    goto4_en = goto_t'(in_q.goto_request) != GOTO_NONE;
    case (goto_t'(in_q.goto_request))
      GOTO_FEET: goto4_tgt = feet_preset_next;
      GOTO_FLAT: goto4_tgt = flat_preset_next;
      default:   goto4_tgt = '0;
    endcase
  end

  tacp_goto u_goto_request (
    .m_in      (m2),
    .cur       (cur3),
    .target    (goto4_tgt),
    .flat      (flat_preset_next),
    .tick      (tick),
    .cfg       (gcfg),
    .enable    (goto4_en),
    .m_out     (m4),
    .restarted (restart4)
  );

  // Build the result and the state for the next tick
  always_comb begin
    fresh4              = fresh2 || restart4;
    raw5                = fresh4 ? m4.base : raw0;
    out_next.pad        = '0;
    out_next.did_work   = any_ev;
    out_next.direction  = m4.dir;
    out_next.position   = clamp_pos(raw5, flat_preset_next, measuring_mode);
    out_next.down_relay = (m4.dir == DIR_DOWN) && (m4.gap == '0);
    out_next.up_relay   = (m4.dir == DIR_UP) && (m4.gap == '0);

    motion_next     = m4;
    motion_next.gap = (m4.gap != '0) ? m4.gap - 1'b1 : '0;
    tick_next       = tick + 1'b1;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_q <= in_item_t'(s_axis_tdata);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_q <= out_next;
  end

  // Advance the tick state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick              <= '0;
      motion.dir        <= DIR_STOP;
      motion.base       <= '0;
      motion.move_start <= '0;
      motion.stop_time  <= '0;
      motion.armed      <= 1'b0;
      motion.gap        <= '0;
      feet_preset       <= FEET_DEFAULT;
      flat_preset       <= FLAT_DEFAULT;
    end else if (fire) begin
      tick        <= tick_next;
      motion      <= motion_next;
      feet_preset <= feet_preset_next;
      flat_preset <= flat_preset_next;
    end
  end

  `TACP_ASSERT_NOW(a_gap_needs_motion, motion.gap != '0, motion.dir != DIR_STOP, "dead time while stopped")
  `TACP_ASSERT_NEXT(a_tick_per_item, fire, tick == TIME_W'($past(tick) + 1'b1), "tick did not advance by one")
  `TACP_ASSERT_NEXT(a_input_held, in_v && !fire, in_v && $stable(in_q), "pending tick lost or overwritten")
  `TACP_ASSERT_NOW(a_relay_matches_dir, out_v && out_q.up_relay, out_q.direction == DIR_UP && !out_q.down_relay, "up relay without up motion")

endmodule

// ===== test/timed_actuator_preset_control_tb.sv =====
`timescale 1ns / 1ps

module timed_actuator_preset_control_tb;
  import tacp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 100;
  // Button codes outside the named set
  localparam logic [EVT_W-1:0] EV_OTHER    = 3'd5;
  localparam logic [EVT_W-1:0] EV_OTHER_HI = 3'd7;
  localparam logic [TIME_W-1:0] HALF_RANGE = {1'b1, {(TIME_W-1){1'b0}}};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  timed_actuator_preset_control dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Actuator model: settings and state
  logic              meas_mode;
  logic [TOL_W-1:0]  tol_cfg;
  logic [OVR_W-1:0]  overrun_cfg;
  logic [GAP_W-1:0]  gap_cfg;
  logic [TIME_W-1:0] tick_cnt;
  dir_t              motion;
  logic [POS_W-1:0]  base_pos;
  logic [TIME_W-1:0] move_t0;
  logic [TIME_W-1:0] stop_t;
  logic              stop_armed;
  logic [GAP_W-1:0]  dead_left;
  logic [POS_W-1:0]  feet_pre;
  logic [POS_W-1:0]  flat_pre;

  in_item_t  pending_ticks[$];
  out_item_t expected_results[$];
  int        ticks_queued = 0;
  int        ticks_accepted = 0;
  int        fails = 0;
  int        results_seen = 0;
  int        moving_seen = 0;
  int        work_seen = 0;
  int        cycles = 0;
  int        src_idle = 0;
  int        sink_idle = 0;
  bit        idle_on = 1'b1;

  function automatic void reset_model();
    meas_mode = MEASURING_RST;
    tol_cfg = TOLERANCE_RST;
    overrun_cfg = OVERRUN_RST;
    gap_cfg = GAP_RST;
    tick_cnt = '0;
    motion = DIR_STOP;
    base_pos = '0;
    move_t0 = '0;
    stop_t = '0;
    stop_armed = 1'b0;
    dead_left = '0;
    feet_pre = FEET_DEFAULT;
    flat_pre = FLAT_DEFAULT;
  endfunction

  // Dead-reckoned position, clamped to the travel range
  function automatic logic [POS_W-1:0] est_position();
    logic [TIME_W-1:0] el;
    logic [POS_W:0]    sum;
    logic [POS_W-1:0]  p;
    el = (dead_left != 0) ? '0 : tick_cnt - move_t0;
    if (el > TIME_W'(POS_MAX)) el = TIME_W'(POS_MAX);
    p = base_pos;
    if (motion == DIR_UP) begin
      p = (el >= TIME_W'(base_pos)) ? '0 : base_pos - el[POS_W-1:0];
    end else if (motion == DIR_DOWN) begin
      sum = {1'b0, base_pos} + {1'b0, el[POS_W-1:0]};
      p = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
    end
    if (p != 0 && p > flat_pre && !meas_mode) p = flat_pre;
    return p;
  endfunction

  function automatic void halt_motion();
    base_pos = est_position();
    motion = DIR_STOP;
    stop_armed = 1'b0;
    dead_left = '0;
  endfunction

  function automatic void begin_motion(dir_t d, logic [GAP_W-1:0] g);
    motion = d;
    dead_left = g;
    move_t0 = tick_cnt + TIME_W'(g);
  endfunction

  // Head for a target and arm the off time
  function automatic void aim_at(logic [POS_W-1:0] target);
    int cur;
    int tgt;
    int tol;
    logic [TIME_W-1:0] travel;
    logic [TIME_W-1:0] origin;
    cur = est_position();
    tgt = target;
    tol = tol_cfg;
    if (tgt >= cur - tol && tgt <= cur + tol) return;
    if (tgt > cur) begin
      if (motion == DIR_UP) begin
        halt_motion();
        begin_motion(DIR_DOWN, gap_cfg);
      end else if (motion == DIR_STOP) begin
        begin_motion(DIR_DOWN, '0);
      end
      travel = tgt - cur;
    end else begin
      if (motion == DIR_DOWN) begin
        halt_motion();
        begin_motion(DIR_UP, gap_cfg);
      end else if (motion == DIR_STOP) begin
        begin_motion(DIR_UP, '0);
      end
      travel = cur - tgt;
    end
    origin = (dead_left != 0) ? move_t0 : tick_cnt;
    if (target == 0 || target == flat_pre) travel = travel + TIME_W'(overrun_cfg);
    stop_t = origin + travel;
    stop_armed = 1'b1;
  endfunction

  function automatic void single_tap();
    int cur;
    int feet;
    int tol;
    cur = est_position();
    feet = feet_pre;
    tol = tol_cfg;
    if (motion == DIR_UP) begin
      if (cur < feet - tol) aim_at('0);
      else aim_at(feet_pre);
    end else if (motion == DIR_DOWN) begin
      if (cur < feet + tol) aim_at(feet_pre);
      else aim_at(flat_pre);
    end
  endfunction

  // One millisecond tick: off time, buttons, presets, goto; then advance time
  function automatic out_item_t actuator_tick(in_item_t it);
    out_item_t res;
    logic [TIME_W-1:0] since;
    logic [POS_W-1:0]  pos;
    logic [EVT_W-1:0]  up;
    logic [EVT_W-1:0]  dn;
    logic              work;
    up = it.up_event;
    dn = it.down_event;
    work = 1'b0;
    since = tick_cnt - stop_t;
    if (stop_armed && since < HALF_RANGE) halt_motion();

    if (up != 0 || dn != 0) begin
      work = 1'b1;
      if (motion == DIR_STOP) begin
        if (dn == EV_PRESSED) begin_motion(DIR_DOWN, '0);
        else if (up == EV_PRESSED) begin_motion(DIR_UP, '0);
      end else begin
        pos = est_position();
        if (pos > 0 && pos < flat_pre) begin
          if (dn == EV_PRESSED || up == EV_PRESSED) halt_motion();
          else if (dn == EV_SINGLE || up == EV_SINGLE) single_tap();
          else if (dn == EV_DOUBLE || up == EV_DOUBLE) begin
            if (motion == DIR_UP) aim_at('0);
            else aim_at(flat_pre);
          end else if (dn == EV_LONG || up == EV_LONG) halt_motion();
        end else begin
          halt_motion();
        end
      end
    end

    case (it.preset_request)
      PRE_SAVE_FEET: feet_pre = base_pos;
      PRE_SAVE_FLAT: flat_pre = base_pos;
      PRE_LOAD: begin
        if (it.feet_value != 0 && it.flat_value != 0) begin
          feet_pre = it.feet_value;
          flat_pre = it.flat_value;
        end else begin
          feet_pre = FEET_DEFAULT;
          flat_pre = FLAT_DEFAULT;
        end
      end
      default: ;
    endcase

    case (it.goto_request)
      GOTO_UPRIGHT: aim_at('0);
      GOTO_FEET:    aim_at(feet_pre);
      GOTO_FLAT:    aim_at(flat_pre);
      default: ;
    endcase

    res = '0;
    res.up_relay = (motion == DIR_UP && dead_left == 0);
    res.down_relay = (motion == DIR_DOWN && dead_left == 0);
    res.position = est_position();
    res.direction = motion;
    res.did_work = work;

    tick_cnt = tick_cnt + 1;
    if (dead_left != 0) dead_left = dead_left - 1;
    return res;
  endfunction

  // Random tick: mostly quiet time with sparse buttons, gotos and preset traffic
  function automatic in_item_t random_tick();
    in_item_t it;
    int r;
    int k;
    logic [EVT_W-1:0] code;
    it = '0;
    it.feet_value = POS_W'($urandom);
    it.flat_value = POS_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      k = $urandom_range(0, 9);
      if (k < 3) code = EV_PRESSED;
      else if (k < 5) code = EV_SINGLE;
      else if (k < 7) code = EV_DOUBLE;
      else if (k < 8) code = EV_LONG;
      else code = EVT_W'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0) begin
        it.up_event = code;
        if ($urandom_range(0, 3) == 0) it.down_event = EVT_W'($urandom_range(0, 7));
      end else begin
        it.down_event = code;
        if ($urandom_range(0, 3) == 0) it.up_event = EVT_W'($urandom_range(0, 7));
      end
    end else if (r < 13) begin
      it.goto_request = SEL_W'($urandom_range(1, 3));
    end else if (r < 18) begin
      it.preset_request = SEL_W'($urandom_range(1, 3));
      if (r >= 16) it.goto_request = SEL_W'($urandom_range(1, 3));
      if (it.preset_request == PRE_LOAD) begin
        k = $urandom_range(0, 19);
        if (k < 14) begin
          it.feet_value = POS_W'($urandom_range(5, 100));
          it.flat_value = it.feet_value + POS_W'($urandom_range(10, 250));
        end else if (k < 17) begin
          if ($urandom_range(0, 1) == 0) it.feet_value = '0;
          else it.flat_value = '0;
        end
      end
    end
    return it;
  endfunction

  task automatic add_tick(logic [EVT_W-1:0] up, logic [EVT_W-1:0] dn, logic [SEL_W-1:0] go,
                          logic [SEL_W-1:0] pr, logic [POS_W-1:0] fv, logic [POS_W-1:0] lv);
    in_item_t it;
    it = '0;
    it.up_event = up;
    it.down_event = dn;
    it.goto_request = go;
    it.preset_request = pr;
    it.feet_value = fv;
    it.flat_value = lv;
    pending_ticks.push_back(it);
    ticks_queued++;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_MEASURING: meas_mode = v[0];
      CFG_TOLERANCE: tol_cfg = v[TOL_W-1:0];
      CFG_OVERRUN:   overrun_cfg = v[OVR_W-1:0];
      CFG_GAP:       gap_cfg = v[GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic m, logic [TOL_W-1:0] t, logic [OVR_W-1:0] o,
                          logic [GAP_W-1:0] g);
    write_reg(CFG_MEASURING, CFG_DATA_W'(m));
    write_reg(CFG_TOLERANCE, CFG_DATA_W'(t));
    write_reg(CFG_OVERRUN, CFG_DATA_W'(o));
    write_reg(CFG_GAP, CFG_DATA_W'(g));
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Wait until every tick is accepted and every result is back, then settle
  task automatic drain();
    while (!(ticks_accepted == ticks_queued && expected_results.size() == 0))
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) begin
      pending_ticks.push_back(random_tick());
      ticks_queued++;
    end
    drain();
  endtask

  // Feed ticks from the pending queue, with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_idle > 0) begin
        src_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        s_axis_tdata <= pending_ticks.pop_front();
        s_axis_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) src_idle = $urandom_range(1, 9);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Predict the result of every accepted tick
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(actuator_tick(in_item_t'(s_axis_tdata)));
      ticks_accepted++;
    end
  end

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_idle > 0) begin
      sink_idle--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 7) == 0) sink_idle = $urandom_range(1, 9);
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (got.direction != DIR_STOP) moving_seen++;
      if (got.did_work) work_seen++;
      if (expected_results.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: unexpected result, none pending: got %h", $time, m_axis_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.up_relay !== want.up_relay || got.down_relay !== want.down_relay ||
            got.position !== want.position || got.direction !== want.direction ||
            got.did_work !== want.did_work) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result %0d mismatch: expected up=%0b dn=%0b pos=%0d dir=%0d work=%0b, got up=%0b dn=%0b pos=%0d dir=%0d work=%0b",
                     $time, results_seen, want.up_relay, want.down_relay, want.position,
                     want.direction, want.did_work, got.up_relay, got.down_relay,
                     got.position, got.direction, got.did_work);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[timed_actuator_preset_control] ERROR");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: small presets, tight tolerance, short overrun and dead time
    set_regs(1'b0, 8'd2, 10'd5, 8'd3);
    add_tick(EV_NONE, EV_NONE, GOTO_NONE, PRE_LOAD, 16'd0, 16'd500);
    add_tick(EV_NONE, EV_NONE, GOTO_NONE, PRE_LOAD, 16'hFFFF, 16'hFFFF);
    add_tick(EV_NONE, EV_NONE, GOTO_NONE, PRE_LOAD, 16'd6, 16'd12);
    add_tick(EV_OTHER, EV_OTHER_HI, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_PRESSED, EV_NONE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_SINGLE, EV_NONE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_PRESSED, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_NONE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_SINGLE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    repeat (4) add_tick(EV_NONE, EV_NONE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_NONE, GOTO_FLAT, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_DOUBLE, EV_NONE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_NONE, GOTO_UPRIGHT, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_NONE, GOTO_UPRIGHT, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_NONE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_LONG, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_NONE, GOTO_FEET, PRE_SAVE_FEET, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_NONE, GOTO_NONE, PRE_SAVE_FLAT, 16'd0, 16'd0);
    add_tick(EV_PRESSED, EV_PRESSED, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_NONE, EV_DOUBLE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    add_tick(EV_LONG, EV_NONE, GOTO_NONE, PRE_NONE, 16'd0, 16'd0);
    drain();

    // Random phases across settings, extremes included
    set_regs(1'b0, 8'd0, 10'd0, 8'd0);
    random_phase(200);
    set_regs(1'b1, 8'd255, 10'd1023, 8'd255);
    random_phase(200);
    set_regs(1'b0, 8'd5, 10'd20, 8'd10);
    random_phase(250);
    set_regs(1'b1, 8'd3, 10'd0, 8'd3);
    random_phase(250);

    // Last stretch at full rate
    idle_on = 1'b0;
    src_idle = 0;
    sink_idle = 0;
    set_regs(1'($urandom_range(0, 1)), TOL_W'($urandom_range(0, 15)),
             OVR_W'($urandom_range(0, 40)), GAP_W'($urandom_range(0, 20)));
    random_phase(300);
    repeat (10) @(posedge clk);

    $display("Checked %0d tick results over six register settings (%0d ticks accepted).",
             results_seen, ticks_accepted);
    $display("Actuator in motion on %0d ticks, button events handled on %0d; %0d mismatches.",
             moving_seen, work_seen, fails);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("[timed_actuator_preset_control] OK");
    end else begin
      $display("[timed_actuator_preset_control] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tacp_pkg.sv
rtl/tacp_goto.sv
rtl/timed_actuator_preset_control.sv
test/timed_actuator_preset_control_tb.sv
